// ----- design/ffha_pkg.sv -----
// Shared types and constants of the first-fit heap allocator.
// Depends on nothing; every design file imports it.
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int FREE_SLOTS_DEF   = 32;
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int ALIGN_BYTES      = 8;
    localparam int WORD_W           = 32;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OUT_OF_MEM = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NULL_FREE  = 2'd3
    } status_t;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_CHK,
        S_SCAN_RD,
        S_SCAN_CK,
        S_DEL_RD,
        S_DEL_WR,
        S_PAGE_RUN,
        S_PAGE_TOP,
        S_PUT_RD,
        S_PUT_CK,
        S_PUT_JOIN,
        S_PUT_WR,
        S_INS_RD,
        S_INS_WR,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] length;
    } free_entry_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [WORD_W-1:0] request_bytes;
        logic [WORD_W-1:0] user_pointer;
        logic [WORD_W-1:0] block_bytes;
    } in_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_pointer;
        logic [WORD_W-1:0] granted_bytes;
        status_t           status;
    } out_beat_t;

endpackage

// ----- design/ffha_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends only on ffha_pkg, for the default depth.
`timescale 1ns / 1ps

module ffha_ram
    import ffha_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = FREE_SLOTS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/first_fit_heap_allocator.sv -----
// First-fit heap allocator: one request in flight, sequenced over the free table RAM.
// An allocate scans the free entries in order and shrinks or removes the first that fits,
// or else takes a page run from the bump pointer and returns its remainder to the table.
// A free walks the entries below the block, then merges it with neighbours or shifts to insert it.
// One beat at a time, paced by the single RAM port pair; s_ready is high only while idle.
// Reset (aresetn low, synchronous): table empty, bump pointer and heap limit zero.
`timescale 1ns / 1ps

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int FREE_SLOTS   = FREE_SLOTS_DEF,
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_beat_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_beat_t         m_data,
    input  logic              cfg_we,
    input  cfg_index_t        cfg_index,
    input  logic [WORD_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(FREE_SLOTS);
    localparam int CNT_W = $clog2(FREE_SLOTS + 1);
    localparam int ENT_W = 2 * WORD_W;
    localparam logic [33:0] HDR34   = 34'(HEADER_BYTES);
    localparam logic [33:0] ALIGN34 = 34'(ALIGN_BYTES - 1);
    localparam logic [33:0] PAGE34  = 34'(PAGE_BYTES - 1);
    localparam logic [33:0] SPLIT34 = 34'(HEADER_BYTES + 8);
    localparam logic [WORD_W-1:0] HDR32 = WORD_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(FREE_SLOTS);

    seq_state_t state_reg, state_next;

    logic [33:0]       total_reg, total_next;
    logic [33:0]       run_reg, run_next;
    logic [WORD_W-1:0] put_start_reg, put_start_next;
    logic [WORD_W-1:0] put_len_reg, put_len_next;
    logic              from_alloc_reg, from_alloc_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  entries_reg, entries_next;
    free_entry_t       prev_reg, prev_next;
    free_entry_t       cur_reg, cur_next;
    logic              prev_valid_reg, prev_valid_next;
    logic              cur_valid_reg, cur_valid_next;
    logic              left_reg, left_next;
    logic              right_reg, right_next;
    out_beat_t         res_reg, res_next;
    out_beat_t         out_reg, out_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] bump_reg, bump_next;
    logic [WORD_W-1:0] limit_reg, limit_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    free_entry_t       ram_wdata, rd_entry;
    logic [ENT_W-1:0]  ram_rdata;

    // Shared conditions.
    logic        scan_end, del_end, ins_end, fits, split_ok, rd_below;
    logic        run_ovf, top_ovf, remainder, table_full, out_free;
    logic [33:0] top_sum;

    assign rd_entry   = free_entry_t'(ram_rdata);
    assign scan_end   = (idx_reg == entries_reg);
    assign del_end    = ({1'b0, idx_reg} + 1'b1) >= {1'b0, entries_reg};
    assign ins_end    = (idx_reg == pos_reg);
    assign fits       = {2'b00, rd_entry.length} >= total_reg;
    assign split_ok   = {2'b00, rd_entry.length} >= (total_reg + SPLIT34);
    assign rd_below   = rd_entry.start < put_start_reg;
    assign top_sum    = {2'b00, bump_reg} + run_reg;
    assign run_ovf    = (run_reg[33:32] != 2'b00);
    assign top_ovf    = top_sum > {2'b00, limit_reg};
    assign remainder  = run_reg > (total_reg + SPLIT34);
    assign table_full = (entries_reg >= SLOTS_CNT);
    assign out_free   = !m_valid_reg || m_ready;

    ffha_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FREE_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.opcode == OP_ALLOC) begin
                        state_next = S_ALLOC_CHK;
                    end else if (s_data.user_pointer == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_PUT_RD;
                    end
                end
            end
            S_ALLOC_CHK: state_next = total_reg[33:32] != 2'b00 ? S_DONE : S_SCAN_RD;
            S_SCAN_RD:   state_next = scan_end ? S_PAGE_RUN : S_SCAN_CK;
            S_SCAN_CK: begin
                if (fits) begin
                    state_next = split_ok ? S_DONE : S_DEL_RD;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_DEL_RD:   state_next = del_end ? S_DONE : S_DEL_WR;
            S_DEL_WR:   state_next = S_DEL_RD;
            S_PAGE_RUN: state_next = S_PAGE_TOP;
            S_PAGE_TOP: begin
                if (run_ovf || top_ovf) begin
                    state_next = S_DONE;
                end else begin
                    state_next = remainder ? S_PUT_RD : S_DONE;
                end
            end
            S_PUT_RD:   state_next = scan_end ? S_PUT_JOIN : S_PUT_CK;
            S_PUT_CK:   state_next = rd_below ? S_PUT_RD : S_PUT_JOIN;
            S_PUT_JOIN: state_next = S_PUT_WR;
            S_PUT_WR: begin
                if (left_reg && right_reg) begin
                    state_next = S_DEL_RD;
                end else if (left_reg || right_reg || table_full) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: state_next = ins_end ? S_DONE : S_INS_WR;
            S_INS_WR: state_next = S_INS_RD;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and table access.
    always_comb begin
        total_next      = total_reg;
        run_next        = run_reg;
        put_start_next  = put_start_reg;
        put_len_next    = put_len_reg;
        from_alloc_next = from_alloc_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        entries_next    = entries_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        prev_valid_next = prev_valid_reg;
        cur_valid_next  = cur_valid_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        bump_next       = bump_reg;
        limit_next      = limit_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[IDX_W-1:0];
        ram_wdata       = '0;
        ram_raddr       = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                res_next        = '{result_pointer: '0, granted_bytes: '0, status: ST_OK};
                total_next      = ({2'b00, s_data.request_bytes} + HDR34 + ALIGN34) & ~ALIGN34;
                put_start_next  = s_data.user_pointer - HDR32;
                put_len_next    = s_data.block_bytes;
                from_alloc_next = 1'b0;
                idx_next        = '0;
                prev_valid_next = 1'b0;
                if (s_data.opcode == OP_FREE && s_data.user_pointer == '0) begin
                    res_next.status = ST_NULL_FREE;
                end
            end
            S_ALLOC_CHK: begin
                if (total_reg[33:32] != 2'b00) begin
                    res_next.status = ST_OUT_OF_MEM;
                end
            end
            S_SCAN_RD: ;
            S_SCAN_CK: begin
                if (fits) begin
                    res_next.result_pointer = rd_entry.start + HDR32;
                    if (split_ok) begin
                        ram_we                 = 1'b1;
                        ram_wdata.start        = rd_entry.start + total_reg[31:0];
                        ram_wdata.length       = rd_entry.length - total_reg[31:0];
                        res_next.granted_bytes = total_reg[31:0];
                    end else begin
                        res_next.granted_bytes = rd_entry.length;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DEL_RD: begin
                ram_raddr = IDX_W'(idx_reg + 1'b1);
                if (del_end) begin
                    entries_next = entries_reg - 1'b1;
                end
            end
            S_DEL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = rd_entry;
                idx_next  = idx_reg + 1'b1;
            end
            S_PAGE_RUN: begin
                run_next = (total_reg + PAGE34) & ~PAGE34;
            end
            S_PAGE_TOP: begin
                if (run_ovf || top_ovf) begin
                    res_next.status = ST_OUT_OF_MEM;
                end else begin
                    bump_next               = top_sum[31:0];
                    res_next.result_pointer = bump_reg + HDR32;
                    res_next.granted_bytes  = run_reg[31:0];
                    put_start_next          = bump_reg + total_reg[31:0];
                    put_len_next            = run_reg[31:0] - total_reg[31:0];
                    from_alloc_next         = 1'b1;
                    idx_next                = '0;
                    prev_valid_next         = 1'b0;
                end
            end
            S_PUT_RD: begin
                if (scan_end) begin
                    cur_valid_next = 1'b0;
                end
            end
            S_PUT_CK: begin
                if (rd_below) begin
                    prev_next       = rd_entry;
                    prev_valid_next = 1'b1;
                    idx_next        = idx_reg + 1'b1;
                end else begin
                    cur_next       = rd_entry;
                    cur_valid_next = 1'b1;
                end
            end
            S_PUT_JOIN: begin
                pos_next   = idx_reg;
                right_next = cur_valid_reg && (put_start_reg + put_len_reg == cur_reg.start);
                left_next  = prev_valid_reg &&
                             (prev_reg.start + prev_reg.length == put_start_reg);
                if (cur_valid_reg && (put_start_reg + put_len_reg == cur_reg.start)) begin
                    put_len_next = put_len_reg + cur_reg.length;
                end
            end
            S_PUT_WR: begin
                if (left_reg) begin
                    ram_we           = 1'b1;
                    ram_waddr        = IDX_W'(pos_reg - 1'b1);
                    ram_wdata.start  = prev_reg.start;
                    ram_wdata.length = prev_reg.length + put_len_reg;
                    idx_next         = pos_reg;
                end else if (right_reg) begin
                    ram_we           = 1'b1;
                    ram_waddr        = pos_reg[IDX_W-1:0];
                    ram_wdata.start  = put_start_reg;
                    ram_wdata.length = put_len_reg;
                end else if (!table_full) begin
                    idx_next = entries_reg;
                end
                // A rejected remainder leaves the whole page run granted.
                if (left_reg || right_reg) begin
                    if (from_alloc_reg) begin
                        res_next.granted_bytes = total_reg[31:0];
                    end
                end else if (table_full && !from_alloc_reg) begin
                    res_next.status = ST_TABLE_FULL;
                end
            end
            S_INS_RD: begin
                ram_raddr = IDX_W'(idx_reg - 1'b1);
                if (ins_end) begin
                    ram_we           = 1'b1;
                    ram_waddr        = pos_reg[IDX_W-1:0];
                    ram_wdata.start  = put_start_reg;
                    ram_wdata.length = put_len_reg;
                    entries_next     = entries_reg + 1'b1;
                    if (from_alloc_reg) begin
                        res_next.granted_bytes = total_reg[31:0];
                    end
                end
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_wdata = rd_entry;
                idx_next  = idx_reg - 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_HEAP_BASE:  bump_next  = cfg_wdata;
                CFG_HEAP_LIMIT: limit_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            entries_reg <= '0;
            bump_reg    <= '0;
            limit_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            entries_reg <= entries_next;
            bump_reg    <= bump_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg      <= total_next;
        run_reg        <= run_next;
        put_start_reg  <= put_start_next;
        put_len_reg    <= put_len_next;
        from_alloc_reg <= from_alloc_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        prev_valid_reg <= prev_valid_next;
        cur_valid_reg  <= cur_valid_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_entries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_reg <= SLOTS_CNT)
        else $error("free table count exceeds its capacity");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == S_DONE))
        else $error("result beat appeared outside the completion step");

    a_entries_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg == S_IDLE) |-> $stable(entries_reg))
        else $error("free table count changed while idle");

    a_entries_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(entries_reg) |->
            (entries_reg == $past(entries_reg) + 1'b1 ||
             entries_reg == $past(entries_reg) - 1'b1))
        else $error("free table count moved by more than one entry");

endmodule
